FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the insertion-ordered key set RTL.
// No dependencies; set NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/iokset_pkg.sv
// Package for the insertion-ordered key set: command and status codes,
// fixed field widths, parameter defaults and the controller command struct.
package iokset_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 32;

	localparam int CMD_W    = 3;
	localparam int KEYIO_W  = 32;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 6;
	localparam int OCC_W    = 7;

	localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FIND     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

	// Step commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture command and key of an accepted transaction
		logic cmp;    // compare the key against every live cell
		logic upd;    // apply the command to the cells, issue the result
	} dp_cmd_t;

endpackage

FILE: hw/rtl/insertion_ordered_key_set_core.sv
// Insertion-ordered key set, top level: sequencer plus cell datapath.
// Depends on iokset_pkg, iokset_ctrl, iokset_dp and assert_macros.svh.
//
// Result: done pulses for one cycle, registered from the update step that follows
// the compare step; a new transaction is accepted during the update/shift step over
// the key cells, since busy is high only during the compare.
// Reset: arst_n clears the sequencer, the key count and done; key cells are not reset.
`include "assert_macros.svh"

module insertion_ordered_key_set_core
	import iokset_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,  // number of key cells
	parameter int KEY_BITS = KEY_BITS_DEF   // stored key width
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    command,
	input  logic [KEYIO_W-1:0]  key_in,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [POS_W-1:0]    position,
	output logic [KEYIO_W-1:0]  key_out,
	output logic [OCC_W-1:0]    occupancy
);

	// Step commands: load on accept, compare, then update and issue result.
	dp_cmd_t step_cmd;

	iokset_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (step_cmd)
	);

	// Cells hold keys oldest first; removal shifts later keys down one place.
	iokset_dp #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (step_cmd),
		.command   (command),
		.key_in    (key_in),
		.done      (done),
		.status    (status),
		.found     (found),
		.position  (position),
		.key_out   (key_out),
		.occupancy (occupancy)
	);

	// A result transaction must come from an update, which is never busy.
	`ASSERT_IMPL(a_done_not_busy, clk, arst_n, done, !$past(busy), "result without update step")
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted transaction not compared")
	`ASSERT_NEXT(a_busy_once, clk, arst_n, busy, !busy, "compare held longer than one cycle")

endmodule

FILE: hw/rtl/iokset_ctrl.sv
// Sequencer for the insertion-ordered key set: accept, compare, update.
// Depends on iokset_pkg (dp_cmd_t) and assert_macros.svh.
`include "assert_macros.svh"

module iokset_ctrl
	import iokset_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output dp_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	// Busy only while comparing; the update cycle can take the next transaction.
	assign busy   = (state_q == S_CMP);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  state_d = accept ? S_CMP : S_IDLE;
			S_CMP:   state_d = S_UPD;
			S_UPD:   state_d = accept ? S_CMP : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.load = accept;
	assign cmd.cmp  = (state_q == S_CMP);
	assign cmd.upd  = (state_q == S_UPD);

	`ASSERT_NEXT(a_accept_to_cmp, clk, arst_n, accept, state_q == S_CMP, "accept did not start compare")
	`ASSERT_NEXT(a_cmp_to_upd, clk, arst_n, state_q == S_CMP, state_q == S_UPD, "compare not followed by update")
	`ASSERT_ALWAYS(a_single_step, clk, arst_n, $onehot0({cmd.cmp, cmd.upd}), "compare and update overlap")

endmodule

FILE: hw/rtl/iokset_dp.sv
// Datapath of the insertion-ordered key set: key cells with parallel compare,
// shift-down on removal, occupancy count and result registers.
// Depends on iokset_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iokset_dp
	import iokset_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [CMD_W-1:0]    command,
	input  logic [KEYIO_W-1:0]  key_in,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [POS_W-1:0]    position,
	output logic [KEYIO_W-1:0]  key_out,
	output logic [OCC_W-1:0]    occupancy
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] cells_q [CAPACITY];
	logic [KEY_BITS-1:0] cell_nxt [CAPACITY];
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;

	logic [CAPACITY-1:0] match;
	logic                hit_enc;
	logic [IDX_W-1:0]    pos_enc;
	logic                hit_q;
	logic [IDX_W-1:0]    pos_q;

	logic                wr_en;
	logic                shift_pop;
	logic                shift_del;
	logic [CAPACITY-1:0] shift_en;

	logic [STATUS_W-1:0] status_d;
	logic                found_d;
	logic [POS_W-1:0]    pos_d;
	logic [KEYIO_W-1:0]  kout_d;

	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic                found_q;
	logic [POS_W-1:0]    pos_res_q;
	logic [KEYIO_W-1:0]  kout_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			key_q <= KEY_BITS'(key_in);
		end
	end

	// Compare against all live cells; keys are distinct, so at most one hits.
	always_comb begin
		pos_enc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CNT_W'(i) < count_q) && (cells_q[i] == key_q);
			if (match[i]) begin
				pos_enc = pos_enc | IDX_W'(i);
			end
		end
		hit_enc = |match;
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			hit_q <= hit_enc;
			pos_q <= pos_enc;
		end
	end

	always_comb begin
		status_d  = ST_OK;
		found_d   = 1'b0;
		pos_d     = '0;
		kout_d    = '0;
		count_d   = count_q;
		wr_en     = 1'b0;
		shift_pop = 1'b0;
		shift_del = 1'b0;
		unique case (cmd_q)
			CMD_APPEND: begin
				if (hit_q) begin
					status_d = ST_DUPLICATE;
					found_d  = 1'b1;
					pos_d    = POS_W'(pos_q);
				end else if (count_q == CNT_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					found_d = 1'b1;
					pos_d   = POS_W'(count_q);
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (hit_q) begin
					found_d   = 1'b1;
					pos_d     = POS_W'(pos_q);
					shift_del = 1'b1;
					count_d   = count_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			CMD_FIND: begin
				if (hit_q) begin
					found_d = 1'b1;
					pos_d   = POS_W'(pos_q);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			CMD_CONTAINS: begin
				found_d = hit_q;
				pos_d   = hit_q ? POS_W'(pos_q) : '0;
			end
			CMD_POP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					found_d   = 1'b1;
					kout_d    = KEYIO_W'(cells_q[0]);
					shift_pop = 1'b1;
					count_d   = count_q - CNT_W'(1);
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// Cells at or above the removed place take their upper neighbor.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			shift_en[i] = shift_pop || (shift_del && (IDX_W'(i) >= pos_q));
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g < CAPACITY - 1) begin : g_nxt
			assign cell_nxt[g] = cells_q[g + 1];
		end else begin : g_last
			assign cell_nxt[g] = cells_q[g];
		end

		always_ff @(posedge clk) begin
			if (cmd.upd) begin
				if (wr_en && (count_q == CNT_W'(g))) begin
					cells_q[g] <= key_q;
				end else if (shift_en[g]) begin
					cells_q[g] <= cell_nxt[g];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.upd;
			if (cmd.upd) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			status_q  <= status_d;
			found_q   <= found_d;
			pos_res_q <= pos_d;
			kout_q    <= kout_d;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign found     = found_q;
	assign position  = pos_res_q;
	assign key_out   = kout_q;
	assign occupancy = OCC_W'(count_q);

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY), "count beyond capacity")
	`ASSERT_NEXT(a_count_hold, clk, arst_n, !cmd.upd, $stable(count_q), "count moved outside update")
	`ASSERT_IMPL(a_hit_live, clk, arst_n, cmd.upd && hit_q, CNT_W'(pos_q) < count_q, "hit beyond live cells")

endmodule

FILE: tb/iokset_result_checker.sv
// Result checker for the insertion-ordered key set core: keeps its own copy of
// the key order, predicts each transaction's result and compares every done strobe.
// Depends on iokset_pkg.
module iokset_result_checker
	import iokset_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [CMD_W-1:0]    command,
	input  logic [KEYIO_W-1:0]  key_in,
	input  logic                done,
	input  logic [STATUS_W-1:0] status,
	input  logic                found,
	input  logic [POS_W-1:0]    position,
	input  logic [KEYIO_W-1:0]  key_out,
	input  logic [OCC_W-1:0]    occupancy,
	output int                  mismatches,
	output int                  outstanding,
	output int                  results_checked,
	output int                  full_rejects
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic                hit;
		logic [POS_W-1:0]    pos;
		logic [KEYIO_W-1:0]  popped;
		logic [OCC_W-1:0]    occ;
	} set_result_t;

	// Key width equals the port width at the default build, so keys need no masking.
	logic [KEYIO_W-1:0] held_keys [CAPACITY_DEF];
	int                 held_count;
	set_result_t        expected_results [$];

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 25)
			$display("[%0t] result %0d: %s", $time, results_checked, what);
	endtask

	function automatic bit locate_key(input logic [KEYIO_W-1:0] key, output int idx);
		idx = 0;
		for (int i = 0; i < held_count; i++) begin
			if (held_keys[i] == key) begin
				idx = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Close the gap: later keys move down one place.
	task automatic drop_key_at(input int idx);
		for (int i = idx; i < held_count - 1; i++)
			held_keys[i] = held_keys[i + 1];
		held_count--;
	endtask

	task automatic apply_set_command(input logic [CMD_W-1:0] cmd,
			input logic [KEYIO_W-1:0] key, output set_result_t res);
		int idx;
		bit hit;
		res = '0;
		res.st = ST_OK;
		hit = locate_key(key, idx);
		case (cmd)
			CMD_APPEND: begin
				if (hit) begin
					res.st = ST_DUPLICATE;
					res.hit = 1'b1;
					res.pos = POS_W'(idx);
				end else if (held_count >= CAPACITY_DEF) begin
					res.st = ST_FULL;
					full_rejects++;
				end else begin
					held_keys[held_count] = key;
					res.hit = 1'b1;
					res.pos = POS_W'(held_count);
					held_count++;
				end
			end
			CMD_DELETE: begin
				if (hit) begin
					res.hit = 1'b1;
					res.pos = POS_W'(idx);
					drop_key_at(idx);
				end else begin
					res.st = ST_NOT_FOUND;
				end
			end
			CMD_FIND: begin
				if (hit) begin
					res.hit = 1'b1;
					res.pos = POS_W'(idx);
				end else begin
					res.st = ST_NOT_FOUND;
				end
			end
			CMD_CONTAINS: begin
				if (hit) begin
					res.hit = 1'b1;
					res.pos = POS_W'(idx);
				end
			end
			CMD_POP: begin
				if (held_count == 0) begin
					res.st = ST_EMPTY;
				end else begin
					res.popped = held_keys[0];
					res.hit = 1'b1;
					drop_key_at(0);
				end
			end
			CMD_CLEAR: held_count = 0;
			default: ;
		endcase
		res.occ = OCC_W'(held_count);
	endtask

	always @(posedge clk) begin
		set_result_t exp_res;
		if (!arst_n) begin
			held_count = 0;
			expected_results.delete();
			mismatches = 0;
			outstanding = 0;
			results_checked = 0;
			full_rejects = 0;
		end else begin
			// Check the strobe first: it belongs to an earlier transaction.
			if (done !== 1'b0) begin
				if (expected_results.size() == 0) begin
					report("result strobe with no transaction outstanding");
				end else begin
					exp_res = expected_results.pop_front();
					if (status !== exp_res.st)
						report($sformatf("status %0d, expected %0d", status, exp_res.st));
					if (found !== exp_res.hit)
						report($sformatf("found %0b, expected %0b", found, exp_res.hit));
					if (position !== exp_res.pos)
						report($sformatf("position %0d, expected %0d", position, exp_res.pos));
					if (key_out !== exp_res.popped)
						report($sformatf("key_out %h, expected %h", key_out, exp_res.popped));
					if (occupancy !== exp_res.occ)
						report($sformatf("occupancy %0d, expected %0d", occupancy, exp_res.occ));
					results_checked++;
				end
			end
			if (start && !busy) begin
				apply_set_command(command, key_in, exp_res);
				expected_results.insert(expected_results.size(), exp_res);
			end
			outstanding = expected_results.size();
		end
	end

endmodule

FILE: tb/insertion_ordered_key_set_core_tb.sv
// Testbench top for insertion_ordered_key_set_core: clock, reset and command stimulus.
// Depends on iokset_pkg, the core RTL and iokset_result_checker.
module insertion_ordered_key_set_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import iokset_pkg::*;

	// Unused command codes; the core must treat them as no operation.
	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

	localparam int RANDOM_ITEMS = 1700;
	localparam int POOL_SIZE    = 96;      // more keys than cells, so appends can run full
	localparam int CYCLE_LIMIT  = 200000;  // far above the slowest correct run

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [CMD_W-1:0]    command = '0;
	logic [KEYIO_W-1:0]  key_in = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [POS_W-1:0]    position;
	logic [KEYIO_W-1:0]  key_out;
	logic [OCC_W-1:0]    occupancy;

	int chk_mismatches;
	int chk_outstanding;
	int chk_results;
	int chk_full_rejects;

	int                 sent = 0;
	int                 burst_left = 0;
	int                 cycles = 0;
	logic [KEYIO_W-1:0] key_pool [POOL_SIZE];

	always #5ns clk = ~clk;

	insertion_ordered_key_set_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.key_in    (key_in),
		.done      (done),
		.status    (status),
		.found     (found),
		.position  (position),
		.key_out   (key_out),
		.occupancy (occupancy)
	);

	iokset_result_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.key_in          (key_in),
		.done            (done),
		.status          (status),
		.found           (found),
		.position        (position),
		.key_out         (key_out),
		.occupancy       (occupancy),
		.mismatches      (chk_mismatches),
		.outstanding     (chk_outstanding),
		.results_checked (chk_results),
		.full_rejects    (chk_full_rejects)
	);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, chk_outstanding);
			$display("insertion_ordered_key_set_core verification failed");
			$finish;
		end
	end

	// Drive one transaction. Called at a falling edge, returns at a falling edge.
	// Bursts of back-to-back transactions alternate with idle gaps; a burst may
	// also start with no gap at all, so start stays high across bursts.
	task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEYIO_W-1:0] key);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			// Toggle junk on the payload while idle; the core must ignore it.
			repeat (gap) begin
				start   <= 1'b0;
				command <= CMD_W'($urandom);
				key_in  <= $urandom;
				@(negedge clk);
			end
		end
		burst_left--;
		start   <= 1'b1;
		command <= cmd;
		key_in  <= key;
		// Hold the transaction until an edge sees start high and busy low.
		do @(posedge clk); while (busy);
		sent++;
		@(negedge clk);
	endtask

	// Mostly keys from the pool, so hits, duplicates and deletes happen often.
	function automatic logic [KEYIO_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	initial begin
		int                 base;
		int                 run_len;
		int                 roll;
		int                 directed;
		logic [CMD_W-1:0]   cmd;

		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 32'h5555_5555;
		key_pool[3] = 32'hAAAA_AAAA;

		// Hold reset low, then release it at a falling edge.
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty-set corners, extreme keys, duplicate, middle delete,
		// spare codes, pops, clear and reuse after clear.
		issue(CMD_POP, 32'h0000_1234);
		issue(CMD_DELETE, '0);
		issue(CMD_FIND, '0);
		issue(CMD_CONTAINS, '0);
		issue(CMD_APPEND, '0);
		issue(CMD_APPEND, '1);
		issue(CMD_APPEND, 32'h5555_5555);
		issue(CMD_APPEND, 32'hAAAA_AAAA);
		issue(CMD_APPEND, '1);
		issue(CMD_FIND, 32'hAAAA_AAAA);
		issue(CMD_CONTAINS, 32'h5555_5555);
		issue(CMD_CONTAINS, 32'h7FFF_FFFF);
		issue(CMD_DELETE, '1);
		issue(CMD_FIND, 32'hAAAA_AAAA);
		issue(CMD_SPARE_A, '1);
		issue(CMD_SPARE_B, '0);
		issue(CMD_POP, '1);
		issue(CMD_POP, '0);
		issue(CMD_CLEAR, '1);
		issue(CMD_FIND, 32'hAAAA_AAAA);
		issue(CMD_POP, '0);
		issue(CMD_APPEND, 32'h8000_0001);
		directed = sent;

		// Random: alternate fill runs that drive the set to full (and past it)
		// with mixed runs of every command against whatever the set now holds.
		while (sent < directed + RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				base = $urandom_range(0, POOL_SIZE - 1);
				if ($urandom_range(0, 1) == 1)
					issue(CMD_CLEAR, $urandom);
				for (int i = 0; i < CAPACITY_DEF + 4; i++)
					issue(CMD_APPEND, key_pool[(base + i) % POOL_SIZE]);
			end else begin
				run_len = $urandom_range(30, 120);
				repeat (run_len) begin
					roll = $urandom_range(0, 99);
					if (roll < 34)      cmd = CMD_APPEND;
					else if (roll < 50) cmd = CMD_DELETE;
					else if (roll < 64) cmd = CMD_FIND;
					else if (roll < 78) cmd = CMD_CONTAINS;
					else if (roll < 92) cmd = CMD_POP;
					else if (roll < 94) cmd = CMD_CLEAR;
					else if (roll < 97) cmd = CMD_SPARE_A;
					else                cmd = CMD_SPARE_B;
					issue(cmd, pick_key());
				end
			end
		end

		// Drain: drop start, wait for every result, then a short tail for strays.
		start <= 1'b0;
		while (chk_outstanding != 0) @(posedge clk);
		repeat (6) @(posedge clk);

		$display("covered %0d transactions (%0d directed), %0d results checked,",
			sent, directed, chk_results);
		$display("%0d appends rejected on a full set, %0d mismatches",
			chk_full_rejects, chk_mismatches);
		if (chk_mismatches == 0 && chk_outstanding == 0) begin
			$display("insertion_ordered_key_set_core verification clean");
		end else begin
			$display("insertion_ordered_key_set_core verification failed");
		end
		$finish;
	end

endmodule
